>>> src/i2sapm_pkg.sv
package i2sapm_pkg;

  // Number of I2S data lines and channels (left and right slot per line).
  localparam int unsigned NUM_LINES    = 3;
  localparam int unsigned NUM_CHANNELS = 6;

  localparam int unsigned RAW_W    = 32;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned PEAK_W   = 16;
  localparam int unsigned SHIFT_W  = 4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SHIFT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MUTE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SHIFT = 2'd2;

  localparam logic               MUTE_RESET        = 1'b0;
  localparam logic [SHIFT_W-1:0] LEFT_SHIFT_RESET  = 4'd4;
  localparam logic [SHIFT_W-1:0] RIGHT_SHIFT_RESET = 4'd1;

  // Result kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_METER  = 1'b1;

  typedef struct packed {
    logic [RAW_W-1:0] line0_left_raw;
    logic [RAW_W-1:0] line0_right_raw;
    logic [RAW_W-1:0] line1_left_raw;
    logic [RAW_W-1:0] line1_right_raw;
    logic [RAW_W-1:0] line2_left_raw;
    logic [RAW_W-1:0] line2_right_raw;
  } in_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] value0;
    logic signed [SAMPLE_W-1:0] value1;
    logic signed [SAMPLE_W-1:0] value2;
    logic signed [SAMPLE_W-1:0] value3;
    logic signed [SAMPLE_W-1:0] value4;
    logic signed [SAMPLE_W-1:0] value5;
    logic [RAW_W-1:0]           line0_peak_raw;
    logic [RAW_W-1:0]           line1_peak_raw;
    logic [RAW_W-1:0]           line2_peak_raw;
    logic                       last;
  } out_t;

endpackage

>>> src/i2sapm_align.sv
module i2sapm_align
  import i2sapm_pkg::*;
(
  input  logic [RAW_W-1:0]    raw,
  input  logic [SHIFT_W-1:0]  shift,
  output logic [SAMPLE_W-1:0] sample,
  output logic [PEAK_W-1:0]   mag
);

  logic [RAW_W-1:0]    shifted;
  logic [SAMPLE_W-1:0] abs_val;

  // Bits pushed past bit 31 are dropped; the top 24 bits form the sample.
  assign shifted = raw << shift;
  assign sample  = shifted[RAW_W-1 -: SAMPLE_W];

  // The most negative sample maps to 0x800000, which is still correct unsigned.
  assign abs_val = sample[SAMPLE_W-1] ? (~sample + {{(SAMPLE_W-1){1'b0}}, 1'b1}) : sample;
  assign mag     = abs_val[SAMPLE_W-1 -: PEAK_W];

endmodule

>>> src/i2s_six_channel_align_peak_meter_unit.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_data   (in_t, six raw slot words)
// out_      output     out_valid / out_stall out_data  (out_t, sample or meter result)
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// One request is taken per cycle while in_stall is low; its sample result sits
// in the output register in the cycle after acceptance, and the input stalls
// while that result waits under out_stall. On the last sample of a frame the
// meter result is held in a second register and follows the sample result;
// the input stalls while it waits. Reset (rst_n low at a clock edge) clears the
// meters, the frame counter and the output valid and sets mute off, shifts 4, 1.
// in_stall follows out_stall combinationally if out_valid and no meter waits.
module i2s_six_channel_align_peak_meter_unit
  import i2sapm_pkg::*;
#(
  parameter int unsigned FRAME_SAMPLES = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The frame counter runs from 0 to FRAME_SAMPLES-1.
  localparam int unsigned IDX_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_SAMPLES - 1);

  // Configuration registers.
  logic               mute_r;
  logic [SHIFT_W-1:0] left_shift_r;
  logic [SHIFT_W-1:0] right_shift_r;

  // Meter state.
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [PEAK_W-1:0] ch_peak_r   [NUM_CHANNELS];
  logic [PEAK_W-1:0] ch_peak_nxt [NUM_CHANNELS];
  logic [PEAK_W-1:0] ln_peak_r   [NUM_LINES];
  logic [PEAK_W-1:0] ln_peak_nxt [NUM_LINES];
  logic [RAW_W-1:0]  ln_word_r   [NUM_LINES];
  logic [RAW_W-1:0]  ln_word_nxt [NUM_LINES];

  // Output side: result register plus one waiting meter result.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic meter_pend_r, meter_pend_nxt;
  out_t meter_data_r, meter_data_nxt;

  logic in_accept;
  logic out_free;
  logic frame_end;

  logic [RAW_W-1:0]    raw      [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] sample   [NUM_CHANNELS];
  logic [PEAK_W-1:0]   mag      [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] value    [NUM_CHANNELS];
  logic [PEAK_W-1:0]   ln_mid_peak [NUM_LINES];
  logic [RAW_W-1:0]    ln_mid_word [NUM_LINES];

  out_t sample_res;
  out_t meter_res;

  assign raw[0] = in_data.line0_left_raw;
  assign raw[1] = in_data.line0_right_raw;
  assign raw[2] = in_data.line1_left_raw;
  assign raw[3] = in_data.line1_right_raw;
  assign raw[4] = in_data.line2_left_raw;
  assign raw[5] = in_data.line2_right_raw;

  // One aligner per channel; even channels are left slots, odd are right slots.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    i2sapm_align u_align (
      .raw    (raw[c]),
      .shift  ((c % 2 == 0) ? left_shift_r : right_shift_r),
      .sample (sample[c]),
      .mag    (mag[c])
    );

    assign ch_peak_nxt[c] = (mag[c] > ch_peak_r[c]) ? mag[c] : ch_peak_r[c];
    assign value[c]       = mute_r ? '0 : sample[c];
  end

  // Per line the left slot is compared first, then the right slot against the
  // possibly updated peak. Ties keep the earlier word.
  for (genvar l = 0; l < NUM_LINES; l++) begin : g_line
    assign ln_mid_peak[l] = (mag[2*l] > ln_peak_r[l]) ? mag[2*l] : ln_peak_r[l];
    assign ln_mid_word[l] = (mag[2*l] > ln_peak_r[l]) ? raw[2*l] : ln_word_r[l];
    assign ln_peak_nxt[l] = (mag[2*l+1] > ln_mid_peak[l]) ? mag[2*l+1] : ln_mid_peak[l];
    assign ln_word_nxt[l] = (mag[2*l+1] > ln_mid_peak[l]) ? raw[2*l+1] : ln_mid_word[l];
  end

  assign frame_end = (idx_r == IDX_LAST);

  // Handshake. A request is taken only when the output register can be loaded
  // at the same edge and no meter result is still waiting.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = meter_pend_r || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sample_res                = '0;
    sample_res.kind           = KIND_SAMPLE;
    sample_res.value0         = value[0];
    sample_res.value1         = value[1];
    sample_res.value2         = value[2];
    sample_res.value3         = value[3];
    sample_res.value4         = value[4];
    sample_res.value5         = value[5];
    sample_res.last           = !frame_end;

    // The meter result reports the peaks including this last sample.
    meter_res                 = '0;
    meter_res.kind            = KIND_METER;
    meter_res.value0          = SAMPLE_W'(ch_peak_nxt[0]);
    meter_res.value1          = SAMPLE_W'(ch_peak_nxt[1]);
    meter_res.value2          = SAMPLE_W'(ch_peak_nxt[2]);
    meter_res.value3          = SAMPLE_W'(ch_peak_nxt[3]);
    meter_res.value4          = SAMPLE_W'(ch_peak_nxt[4]);
    meter_res.value5          = SAMPLE_W'(ch_peak_nxt[5]);
    meter_res.line0_peak_raw  = ln_word_nxt[0];
    meter_res.line1_peak_raw  = ln_word_nxt[1];
    meter_res.line2_peak_raw  = ln_word_nxt[2];
    meter_res.last            = 1'b1;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    meter_pend_nxt = meter_pend_r;
    meter_data_nxt = meter_data_r;

    if (out_free) begin
      if (meter_pend_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = meter_data_r;
        meter_pend_nxt = 1'b0;
      end else if (in_accept) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = sample_res;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end

    if (in_accept && frame_end) begin
      meter_pend_nxt = 1'b1;
      meter_data_nxt = meter_res;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (in_accept) begin
      idx_nxt = frame_end ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      meter_pend_r <= 1'b0;
      idx_r        <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ch_peak_r[c] <= '0;
      end
      for (int l = 0; l < NUM_LINES; l++) begin
        ln_peak_r[l] <= '0;
        ln_word_r[l] <= '0;
      end
    end else begin
      out_valid_r  <= out_valid_nxt;
      meter_pend_r <= meter_pend_nxt;
      idx_r        <= idx_nxt;
      if (in_accept) begin
        // The frame's meters start over once the meter result is captured.
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          ch_peak_r[c] <= frame_end ? '0 : ch_peak_nxt[c];
        end
        for (int l = 0; l < NUM_LINES; l++) begin
          ln_peak_r[l] <= frame_end ? '0 : ln_peak_nxt[l];
          ln_word_r[l] <= frame_end ? '0 : ln_word_nxt[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    meter_data_r <= meter_data_nxt;
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r        <= MUTE_RESET;
      left_shift_r  <= LEFT_SHIFT_RESET;
      right_shift_r <= RIGHT_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MUTE:        mute_r        <= cfg_wdata[0];
        CFG_LEFT_SHIFT:  left_shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_RIGHT_SHIFT: right_shift_r <= cfg_wdata[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/i2sapm_checker.sv
module i2sapm_checker
  import i2sapm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A sample result that is not last is followed at once by its meter result.
  a_meter_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.kind == KIND_SAMPLE && !out_data.last
    |=> out_valid && out_data.kind == KIND_METER)
    else $error("meter result did not follow the frame's last sample");

  // Meter results always close the request.
  a_meter_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_METER |-> out_data.last)
    else $error("meter result without last");

  // Sample results carry no peak words.
  a_sample_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_SAMPLE |->
      out_data.line0_peak_raw == '0 && out_data.line1_peak_raw == '0 &&
      out_data.line2_peak_raw == '0)
    else $error("sample result carries a peak word");

  // Channel peaks are 16-bit magnitudes.
  a_meter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_METER |->
      out_data.value0[23:16] == 8'h00 && out_data.value1[23:16] == 8'h00 &&
      out_data.value2[23:16] == 8'h00 && out_data.value3[23:16] == 8'h00 &&
      out_data.value4[23:16] == 8'h00 && out_data.value5[23:16] == 8'h00)
    else $error("channel peak out of range");

endmodule

bind i2s_six_channel_align_peak_meter_unit i2sapm_checker u_i2sapm_checker (.*);
